@@ design/stereo_schroeder_reverb_q15_assert.svh @@
// Assertion macros shared by the reverb checker.
// Depends on nothing; the including scope supplies clk and rst_n.
`ifndef STEREO_SCHROEDER_REVERB_Q15_ASSERT_SVH
`define STEREO_SCHROEDER_REVERB_Q15_ASSERT_SVH

// Consequent checked in the same cycle as the antecedent.
`define SSR_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Consequent checked in the cycle after the antecedent.
`define SSR_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ design/ssr_pkg.sv @@
// Types, constants and helper functions of the stereo reverb.
// Used by the top level and its checker; depends on nothing.
`default_nettype none

package ssr_pkg;

    localparam int CFG_IDX_W = 3;
    localparam int COEF_W    = 15;

    localparam logic [CFG_IDX_W-1:0] REG_COMB_GAIN = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_DAMPING   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DRY       = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd3;

    localparam logic [14:0] RST_COMB_GAIN = 15'd26213;
    localparam logic [14:0] RST_DAMPING   = 15'd25885;
    localparam logic [14:0] RST_DRY       = 15'd22936;
    localparam logic [14:0] RST_WET       = 15'd9830;

    localparam int COMB_LEN_A    = 1447;
    localparam int COMB_LEN_B    = 1693;
    localparam int COMB_LEN_C    = 1931;
    localparam int COMB_LEN_D    = 2161;
    localparam int ALLPASS_LEN_A = 241;
    localparam int ALLPASS_LEN_B = 83;

    localparam int COMB_TOTAL = COMB_LEN_A + COMB_LEN_B + COMB_LEN_C + COMB_LEN_D;
    localparam int AP_TOTAL   = ALLPASS_LEN_A + ALLPASS_LEN_B;
    localparam int CADDR_W    = $clog2(COMB_TOTAL);
    localparam int AADDR_W    = $clog2(AP_TOTAL);

    localparam logic [CADDR_W-1:0] COMB_BASE [4] = '{
        CADDR_W'(0),
        CADDR_W'(COMB_LEN_A),
        CADDR_W'(COMB_LEN_A + COMB_LEN_B),
        CADDR_W'(COMB_LEN_A + COMB_LEN_B + COMB_LEN_C)
    };
    localparam logic [CADDR_W-1:0] COMB_LAST [4] = '{
        CADDR_W'(COMB_LEN_A - 1),
        CADDR_W'(COMB_LEN_A + COMB_LEN_B - 1),
        CADDR_W'(COMB_LEN_A + COMB_LEN_B + COMB_LEN_C - 1),
        CADDR_W'(COMB_TOTAL - 1)
    };
    localparam logic [AADDR_W-1:0] AP_BASE [2] = '{
        AADDR_W'(0),
        AADDR_W'(ALLPASS_LEN_A)
    };
    localparam logic [AADDR_W-1:0] AP_LAST [2] = '{
        AADDR_W'(ALLPASS_LEN_A - 1),
        AADDR_W'(AP_TOTAL - 1)
    };

    typedef struct packed {
        logic signed [15:0] left_sample;
        logic signed [15:0] right_sample;
        logic               block_start;
    } ssr_in_t;

    typedef struct packed {
        logic signed [15:0] left_out;
        logic signed [15:0] right_out;
    } ssr_out_t;

    function automatic logic signed [15:0] sat16(input logic signed [17:0] v);
        logic signed [15:0] r;
        if (v > 18'sd32767) begin
            r = 16'sh7FFF;
        end
        else if (v < -18'sd32768) begin
            r = 16'sh8000;
        end
        else begin
            r = v[15:0];
        end
        return r;
    endfunction

    // One smoothing step: cur + (tgt - cur) * 75 / 256, truncated toward zero.
    function automatic logic [14:0] smooth_step(input logic [14:0] cur,
                                                input logic [14:0] tgt);
        logic signed [15:0] diff;
        logic signed [23:0] prod;
        logic signed [23:0] q;
        logic signed [15:0] sum;
        diff = $signed({1'b0, tgt}) - $signed({1'b0, cur});
        prod = 24'(diff) * 24'sd75;
        if (prod < 0) begin
            q = (prod + 24'sd255) >>> 8;
        end
        else begin
            q = prod >>> 8;
        end
        sum = $signed({1'b0, cur}) + q[15:0];
        return sum[14:0];
    endfunction

endpackage

`default_nettype wire

@@ design/stereo_schroeder_reverb_q15.sv @@
// Stereo Q15 Schroeder reverb: four damped combs and two allpasses per channel.
// Depends on ssr_pkg.
//
//  Channel | Handshake            | Beat contents
//  in      | in_valid / in_ready  | in_data (ssr_in_t)
//  out     | out_valid / out_ready| out_data (ssr_out_t)
//  cfg     | cfg_valid / cfg_ready| cfg_index, cfg_data
//
// One item is finished before the next is accepted: a gain smoothing step, then per
// channel the steps on the single shared multiplier and the registered delay
// memory reads (five per comb, two per allpass, three for the mix).
// After reset a clearing pass zeroes the delay lines before the first input
// beat is taken; configuration beats are taken at any time.
// A finished result waits in the output register while the next beat is accepted.
`default_nettype none

module stereo_schroeder_reverb_q15 (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           in_valid,
    output logic                           in_ready,
    input  ssr_pkg::ssr_in_t               in_data,
    output logic                           out_valid,
    input  logic                           out_ready,
    output ssr_pkg::ssr_out_t              out_data,
    input  logic                           cfg_valid,
    output logic                           cfg_ready,
    input  logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [ssr_pkg::COEF_W-1:0]     cfg_data
);
    import ssr_pkg::*;

    localparam logic [3:0] S_CLEAR  = 4'd0;
    localparam logic [3:0] S_IDLE   = 4'd1;
    localparam logic [3:0] S_SMOOTH = 4'd2;
    localparam logic [3:0] S_CREAD  = 4'd3;
    localparam logic [3:0] S_CDAMP  = 4'd4;
    localparam logic [3:0] S_CLP    = 4'd5;
    localparam logic [3:0] S_CFB    = 4'd6;
    localparam logic [3:0] S_CWR    = 4'd7;
    localparam logic [3:0] S_AREAD  = 4'd8;
    localparam logic [3:0] S_AWR    = 4'd9;
    localparam logic [3:0] S_MDRY   = 4'd10;
    localparam logic [3:0] S_MWET   = 4'd11;
    localparam logic [3:0] S_MSUM   = 4'd12;
    localparam logic [3:0] S_POS    = 4'd13;
    localparam logic [3:0] S_OUT    = 4'd14;

    logic [3:0]          state_reg;
    logic [CADDR_W-1:0]  clr_cnt_reg;
    logic [14:0]         tgt_gain_reg, tgt_damp_reg, tgt_dry_reg, tgt_wet_reg;
    logic [14:0]         sm_gain_reg, sm_damp_reg, sm_dry_reg, sm_wet_reg;
    logic                ch_reg;
    logic [1:0]          cidx_reg;
    logic                aidx_reg;
    logic [CADDR_W-1:0]  comb_addr_reg [4];
    logic [AADDR_W-1:0]  ap_addr_reg [2];
    logic signed [15:0]  lp_reg [8];
    logic                out_valid_reg;

    logic signed [15:0]  x_reg [2];
    logic                blk_reg;
    logic signed [17:0]  sum_reg;
    logic signed [15:0]  apin_reg;
    logic signed [32:0]  prod_reg;
    logic signed [17:0]  acc_reg;
    logic signed [15:0]  res_reg [2];
    ssr_out_t            out_data_reg;

    logic signed [15:0]  comb_mem_left [COMB_TOTAL];
    logic signed [15:0]  comb_mem_right [COMB_TOTAL];
    logic signed [15:0]  ap_mem_left [AP_TOTAL];
    logic signed [15:0]  ap_mem_right [AP_TOTAL];
    logic signed [15:0]  crd_left, crd_right, ard_left, ard_right;

    logic [CADDR_W-1:0]  caddr;
    logic [AADDR_W-1:0]  aaddr;
    logic                c_we_left, c_we_right, a_we_left, a_we_right;
    logic signed [15:0]  c_wdata, a_wdata;
    logic                clr_ap;

    logic [2:0]          lp_idx;
    logic signed [15:0]  cur_lp;
    logic signed [15:0]  comb_y;
    logic signed [15:0]  ap_d;
    logic signed [16:0]  st;
    logic signed [17:0]  vn;
    logic signed [17:0]  ap_o;
    logic [14:0]         mul_a;
    logic signed [16:0]  mul_b;
    logic signed [32:0]  mul_p;
    logic                in_fire, out_load;

    assign in_ready  = (state_reg == S_IDLE);
    assign in_fire   = in_valid && in_ready;
    assign cfg_ready = 1'b1;
    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;
    assign out_load  = (state_reg == S_OUT) && (!out_valid_reg || out_ready);

    assign lp_idx = {ch_reg, cidx_reg};
    assign cur_lp = lp_reg[lp_idx];
    assign comb_y = ch_reg ? crd_right : crd_left;
    assign ap_d   = ch_reg ? ard_right : ard_left;
    assign st     = 17'(cur_lp) + prod_reg[31:15];
    assign vn     = 18'(apin_reg) + 18'(ap_d >>> 1);
    assign ap_o   = 18'(ap_d) - (vn >>> 1);
    assign clr_ap = (clr_cnt_reg < CADDR_W'(AP_TOTAL));

    always_comb
    begin
        mul_a = sm_damp_reg;
        mul_b = comb_y - cur_lp;
        case (state_reg)
            S_CFB:
            begin
                mul_a = sm_gain_reg;
                mul_b = 17'(cur_lp);
            end
            S_MDRY:
            begin
                mul_a = sm_dry_reg;
                mul_b = 17'(x_reg[ch_reg]);
            end
            S_MWET:
            begin
                mul_a = sm_wet_reg;
                mul_b = 17'(apin_reg);
            end
            default:
            begin
                mul_a = sm_damp_reg;
                mul_b = comb_y - cur_lp;
            end
        endcase
    end

    assign mul_p = $signed({1'b0, mul_a}) * mul_b;

    always_comb
    begin
        if (state_reg == S_CLEAR) begin
            caddr      = clr_cnt_reg;
            aaddr      = clr_cnt_reg[AADDR_W-1:0];
            c_wdata    = '0;
            a_wdata    = '0;
            c_we_left  = 1'b1;
            c_we_right = 1'b1;
            a_we_left  = clr_ap;
            a_we_right = clr_ap;
        end
        else begin
            caddr      = comb_addr_reg[cidx_reg];
            aaddr      = ap_addr_reg[aidx_reg];
            c_wdata    = sat16(18'(x_reg[ch_reg]) + prod_reg[32:15]);
            a_wdata    = sat16(vn);
            c_we_left  = (state_reg == S_CWR) && !ch_reg;
            c_we_right = (state_reg == S_CWR) && ch_reg;
            a_we_left  = (state_reg == S_AWR) && !ch_reg;
            a_we_right = (state_reg == S_AWR) && ch_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (c_we_left) begin
            comb_mem_left[caddr] <= c_wdata;
        end
        if (c_we_right) begin
            comb_mem_right[caddr] <= c_wdata;
        end
        crd_left  <= comb_mem_left[caddr];
        crd_right <= comb_mem_right[caddr];
    end

    always_ff @(posedge clk)
    begin
        if (a_we_left) begin
            ap_mem_left[aaddr] <= a_wdata;
        end
        if (a_we_right) begin
            ap_mem_right[aaddr] <= a_wdata;
        end
        ard_left  <= ap_mem_left[aaddr];
        ard_right <= ap_mem_right[aaddr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            tgt_gain_reg  <= RST_COMB_GAIN;
            tgt_damp_reg  <= RST_DAMPING;
            tgt_dry_reg   <= RST_DRY;
            tgt_wet_reg   <= RST_WET;
            sm_gain_reg   <= RST_COMB_GAIN;
            sm_damp_reg   <= RST_DAMPING;
            sm_dry_reg    <= RST_DRY;
            sm_wet_reg    <= RST_WET;
            ch_reg        <= 1'b0;
            cidx_reg      <= '0;
            aidx_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            for (int i = 0; i < 4; i++) begin
                comb_addr_reg[i] <= COMB_BASE[i];
            end
            for (int i = 0; i < 2; i++) begin
                ap_addr_reg[i] <= AP_BASE[i];
            end
            for (int i = 0; i < 8; i++) begin
                lp_reg[i] <= '0;
            end
        end
        else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_COMB_GAIN: tgt_gain_reg <= cfg_data;
                    REG_DAMPING:   tgt_damp_reg <= cfg_data;
                    REG_DRY:       tgt_dry_reg  <= cfg_data;
                    REG_WET:       tgt_wet_reg  <= cfg_data;
                    default:       ;
                endcase
            end

            if (out_load) begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end

            case (state_reg)
                S_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == CADDR_W'(COMB_TOTAL - 1)) begin
                        state_reg <= S_IDLE;
                    end
                end
                S_IDLE:
                begin
                    if (in_fire) begin
                        state_reg <= S_SMOOTH;
                    end
                end
                S_SMOOTH:
                begin
                    if (blk_reg) begin
                        sm_gain_reg <= smooth_step(sm_gain_reg, tgt_gain_reg);
                        sm_damp_reg <= smooth_step(sm_damp_reg, tgt_damp_reg);
                        sm_dry_reg  <= smooth_step(sm_dry_reg, tgt_dry_reg);
                        sm_wet_reg  <= smooth_step(sm_wet_reg, tgt_wet_reg);
                    end
                    ch_reg    <= 1'b0;
                    cidx_reg  <= '0;
                    state_reg <= S_CREAD;
                end
                S_CREAD:  state_reg <= S_CDAMP;
                S_CDAMP:  state_reg <= S_CLP;
                S_CLP:
                begin
                    lp_reg[lp_idx] <= st[15:0];
                    state_reg      <= S_CFB;
                end
                S_CFB:    state_reg <= S_CWR;
                S_CWR:
                begin
                    cidx_reg <= cidx_reg + 1'b1;
                    if (cidx_reg == 2'd3) begin
                        aidx_reg  <= 1'b0;
                        state_reg <= S_AREAD;
                    end
                    else begin
                        state_reg <= S_CREAD;
                    end
                end
                S_AREAD:  state_reg <= S_AWR;
                S_AWR:
                begin
                    aidx_reg <= !aidx_reg;
                    if (aidx_reg) begin
                        state_reg <= S_MDRY;
                    end
                    else begin
                        state_reg <= S_AREAD;
                    end
                end
                S_MDRY:   state_reg <= S_MWET;
                S_MWET:   state_reg <= S_MSUM;
                S_MSUM:
                begin
                    if (ch_reg) begin
                        state_reg <= S_POS;
                    end
                    else begin
                        ch_reg    <= 1'b1;
                        cidx_reg  <= '0;
                        state_reg <= S_CREAD;
                    end
                end
                S_POS:
                begin
                    for (int i = 0; i < 4; i++) begin
                        if (comb_addr_reg[i] == COMB_LAST[i]) begin
                            comb_addr_reg[i] <= COMB_BASE[i];
                        end
                        else begin
                            comb_addr_reg[i] <= comb_addr_reg[i] + 1'b1;
                        end
                    end
                    for (int i = 0; i < 2; i++) begin
                        if (ap_addr_reg[i] == AP_LAST[i]) begin
                            ap_addr_reg[i] <= AP_BASE[i];
                        end
                        else begin
                            ap_addr_reg[i] <= ap_addr_reg[i] + 1'b1;
                        end
                    end
                    state_reg <= S_OUT;
                end
                S_OUT:
                begin
                    if (out_load) begin
                        state_reg <= S_IDLE;
                    end
                end
                default:  state_reg <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire) begin
            x_reg[0] <= in_data.left_sample;
            x_reg[1] <= in_data.right_sample;
            blk_reg  <= in_data.block_start;
        end
        if (state_reg == S_CDAMP || state_reg == S_CFB || state_reg == S_MDRY
            || state_reg == S_MWET) begin
            prod_reg <= mul_p;
        end
        if (state_reg == S_SMOOTH || (state_reg == S_MSUM && !ch_reg)) begin
            sum_reg <= '0;
        end
        else if (state_reg == S_CDAMP) begin
            sum_reg <= sum_reg + 18'(comb_y);
        end
        if (state_reg == S_CWR && cidx_reg == 2'd3) begin
            apin_reg <= sum_reg[17:2];
        end
        else if (state_reg == S_AWR) begin
            apin_reg <= sat16(ap_o);
        end
        if (state_reg == S_MWET) begin
            acc_reg <= prod_reg[32:15];
        end
        if (state_reg == S_MSUM) begin
            res_reg[ch_reg] <= sat16(acc_reg + prod_reg[32:15]);
        end
        if (out_load) begin
            out_data_reg.left_out  <= res_reg[0];
            out_data_reg.right_out <= res_reg[1];
        end
    end

endmodule

`default_nettype wire

@@ design/ssr_checker.sv @@
// Port-level checker for the stereo reverb, bound to the top level.
// Depends on ssr_pkg and stereo_schroeder_reverb_q15_assert.svh.
`default_nettype none
`include "stereo_schroeder_reverb_q15_assert.svh"

module ssr_checker (
    input logic                           clk,
    input logic                           rst_n,
    input logic                           in_valid,
    input logic                           in_ready,
    input ssr_pkg::ssr_in_t               in_data,
    input logic                           out_valid,
    input logic                           out_ready,
    input ssr_pkg::ssr_out_t              out_data,
    input logic                           cfg_valid,
    input logic                           cfg_ready,
    input logic [ssr_pkg::CFG_IDX_W-1:0]  cfg_index,
    input logic [ssr_pkg::COEF_W-1:0]     cfg_data
);
    import ssr_pkg::*;

    `SSR_ASSERT_NEXT(a_out_hold, out_valid && !out_ready, out_valid, "out beat dropped")
    `SSR_ASSERT_NEXT(a_out_stable, out_valid && !out_ready, $stable(out_data), "out data moved")
    `SSR_ASSERT_NEXT(a_busy_after_in, in_valid && in_ready, !in_ready, "took two beats")
    `SSR_ASSERT_NEXT(a_no_instant_out, in_valid && in_ready, !$rose(out_valid), "early result")
    `SSR_ASSERT_NOW(a_cfg_open, cfg_valid, cfg_ready, "config stalled")

endmodule

bind stereo_schroeder_reverb_q15 ssr_checker u_ssr_checker (.*);

`default_nettype wire

@@ bench/stereo_schroeder_reverb_q15_test.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the stereo Q15 Schroeder reverb top level.
// Depends on ssr_pkg and stereo_schroeder_reverb_q15; predicts every output beat.

module stereo_schroeder_reverb_q15_test;
    import ssr_pkg::*;

    typedef struct {
        int l;
        int r;
        bit bs;
        bit typed;
        int el;
        int er;
    } row_t;

    logic clk;
    logic rst_n;
    logic in_valid;
    logic in_ready;
    ssr_in_t in_data;
    logic out_valid;
    logic out_ready;
    ssr_out_t out_data;
    logic cfg_valid;
    logic cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [COEF_W-1:0] cfg_data;

    int errors = 0;
    bit calm = 0;
    bit stim_done = 0;
    ssr_out_t pending_mix[$];

    int comb_len[4] = '{COMB_LEN_A, COMB_LEN_B, COMB_LEN_C, COMB_LEN_D};
    int ap_len[2] = '{ALLPASS_LEN_A, ALLPASS_LEN_B};
    logic signed [15:0] comb_mem[2][4][2161];
    logic signed [15:0] ap_mem[2][2][241];
    logic signed [15:0] lowpass[2][4];
    int comb_pos[4];
    int ap_pos[2];
    int gain_now, damp_now, dry_now, wet_now;
    int gain_goal, damp_goal, dry_goal, wet_goal;

    row_t opening[12] = '{
        '{0, 0, 0, 1, 0, 0},
        '{32767, -32768, 0, 1, 22935, -22936},
        '{-32768, 32767, 0, 1, -22936, 22935},
        '{1, -1, 0, 1, 0, -1},
        '{-1, 1, 0, 1, -1, 0},
        '{32767, 32767, 1, 0, 0, 0},
        '{-32768, -32768, 1, 0, 0, 0},
        '{12345, -23456, 1, 0, 0, 0},
        '{0, 0, 1, 0, 0, 0},
        '{32767, -32768, 0, 0, 0, 0},
        '{-32768, 32767, 1, 0, 0, 0},
        '{21845, -10923, 0, 0, 0, 0}
    };

    stereo_schroeder_reverb_q15 dut (
        .clk(clk), .rst_n(rst_n),
        .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
        .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #20ms;
        $display("*** FAILED ***");
        $finish;
    end

    function automatic int clip16(int v);
        if (v > 32767)
        begin
            return 32767;
        end
        if (v < -32768)
        begin
            return -32768;
        end
        return v;
    endfunction

    function automatic int glide(int cur, int goal);
        return cur + ((goal - cur) * 75) / 256;
    endfunction

    function automatic int reverb_channel(int ch, int x);
        int sum;
        int y;
        int st;
        int d;
        int vn;
        int o;
        int p;
        sum = 0;
        for (int c = 0; c < 4; c++)
        begin
            p = comb_pos[c];
            y = comb_mem[ch][c][p];
            st = lowpass[ch][c];
            st = st + ((damp_now * (y - st)) >>> 15);
            lowpass[ch][c] = 16'(st);
            comb_mem[ch][c][p] = 16'(clip16(x + ((gain_now * st) >>> 15)));
            sum += y;
        end
        o = sum >>> 2;
        for (int a = 0; a < 2; a++)
        begin
            p = ap_pos[a];
            d = ap_mem[ch][a][p];
            vn = o + ((16384 * d) >>> 15);
            ap_mem[ch][a][p] = 16'(clip16(vn));
            o = clip16(d - ((16384 * vn) >>> 15));
        end
        return clip16(((dry_now * x) >>> 15) + ((wet_now * o) >>> 15));
    endfunction

    function automatic ssr_out_t predict_mix(ssr_in_t beat);
        ssr_out_t res;
        if (beat.block_start)
        begin
            gain_now = glide(gain_now, gain_goal);
            damp_now = glide(damp_now, damp_goal);
            dry_now = glide(dry_now, dry_goal);
            wet_now = glide(wet_now, wet_goal);
        end
        res.left_out = 16'(reverb_channel(0, int'(beat.left_sample)));
        res.right_out = 16'(reverb_channel(1, int'(beat.right_sample)));
        for (int c = 0; c < 4; c++)
        begin
            comb_pos[c] = (comb_pos[c] + 1 >= comb_len[c]) ? 0 : comb_pos[c] + 1;
        end
        for (int a = 0; a < 2; a++)
        begin
            ap_pos[a] = (ap_pos[a] + 1 >= ap_len[a]) ? 0 : ap_pos[a] + 1;
        end
        return res;
    endfunction

    task automatic send_sample(int l, int r, bit bs, bit typed, int el, int er);
        ssr_in_t beat;
        ssr_out_t res;
        if (!calm && $urandom_range(99) < 20)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 8)) @(posedge clk);
        end
        beat.left_sample = 16'(l);
        beat.right_sample = 16'(r);
        beat.block_start = bs;
        in_valid <= 1'b1;
        in_data <= beat;
        do
        begin
            @(posedge clk);
        end
        while (!in_ready);
        res = predict_mix(beat);
        if (typed)
        begin
            res.left_out = 16'(el);
            res.right_out = 16'(er);
        end
        pending_mix.push_back(res);
    endtask

    task automatic write_reg(int idx, int val);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_IDX_W'(idx);
        cfg_data <= COEF_W'(val);
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        case (CFG_IDX_W'(idx))
            REG_COMB_GAIN: gain_goal = val & 32'h7FFF;
            REG_DAMPING: damp_goal = val & 32'h7FFF;
            REG_DRY: dry_goal = val & 32'h7FFF;
            REG_WET: wet_goal = val & 32'h7FFF;
            default: ;
        endcase
    endtask

    task automatic retune(int g, int d, int dr, int w);
        in_valid <= 1'b0;
        wait (pending_mix.size() == 0);
        repeat (100) @(posedge clk);
        write_reg(REG_COMB_GAIN, g);
        write_reg(REG_DAMPING, d);
        write_reg(REG_DRY, dr);
        write_reg(REG_WET, w);
        write_reg($urandom_range(4, 7), $urandom_range(32767));
        cfg_valid <= 1'b0;
    endtask

    task automatic random_run(int count);
        int l;
        int r;
        int style;
        for (int i = 0; i < count; i++)
        begin
            style = $urandom_range(9);
            if (style < 4)
            begin
                l = $signed(16'($urandom));
                r = $signed(16'($urandom));
            end
            else if (style < 7)
            begin
                l = $urandom_range(0, 4000) - 2000;
                r = $urandom_range(0, 4000) - 2000;
            end
            else
            begin
                l = $urandom_range(1) ? 32767 : -32768;
                r = $urandom_range(1) ? 32767 : -32768;
            end
            send_sample(l, r, $urandom_range(3) == 0, 0, 0, 0);
        end
    endtask

    initial
    begin
        for (int ch = 0; ch < 2; ch++)
        begin
            for (int c = 0; c < 4; c++)
            begin
                lowpass[ch][c] = 0;
                for (int k = 0; k < 2161; k++)
                begin
                    comb_mem[ch][c][k] = 0;
                end
            end
            for (int a = 0; a < 2; a++)
            begin
                for (int k = 0; k < 241; k++)
                begin
                    ap_mem[ch][a][k] = 0;
                end
            end
        end
        comb_pos = '{0, 0, 0, 0};
        ap_pos = '{0, 0};
        gain_now = RST_COMB_GAIN;
        damp_now = RST_DAMPING;
        dry_now = RST_DRY;
        wet_now = RST_WET;
        gain_goal = gain_now;
        damp_goal = damp_now;
        dry_goal = dry_now;
        wet_goal = wet_now;

        rst_n <= 1'b0;
        in_valid <= 1'b0;
        in_data <= '0;
        cfg_valid <= 1'b0;
        cfg_index <= '0;
        cfg_data <= '0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        foreach (opening[i])
        begin
            send_sample(opening[i].l, opening[i].r, opening[i].bs, opening[i].typed,
                        opening[i].el, opening[i].er);
        end
        random_run(110);
        retune(29490, 32767, 32767, 32767);
        calm = 1;
        random_run(110);
        calm = 0;
        retune(0, 0, 0, 0);
        random_run(100);
        retune(22937, 9830, 0, 32767);
        random_run(110);
        retune($urandom_range(32767), $urandom_range(32767),
               $urandom_range(32767), $urandom_range(32767));
        random_run(110);
        in_valid <= 1'b0;
        stim_done = 1;
    end

    initial
    begin
        out_ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n && out_valid && out_ready)
            begin
                if (pending_mix.size() == 0)
                begin
                    $display("%0t: unexpected beat, actual %0d %0d", $realtime,
                             out_data.left_out, out_data.right_out);
                    errors++;
                end
                else if (out_data !== pending_mix[0])
                begin
                    $display("%0t: expected %0d %0d, actual %0d %0d", $realtime,
                             pending_mix[0].left_out, pending_mix[0].right_out,
                             out_data.left_out, out_data.right_out);
                    errors++;
                    void'(pending_mix.pop_front());
                end
                else
                begin
                    void'(pending_mix.pop_front());
                end
            end
            out_ready <= calm || ($urandom_range(99) >= 20);
        end
    end

    initial
    begin
        wait (stim_done && pending_mix.size() == 0);
        repeat (200) @(posedge clk);
        if (errors == 0 && pending_mix.size() == 0)
        begin
            $display("*** PASSED ***");
        end
        else
        begin
            $display("*** FAILED ***");
        end
        $finish;
    end

endmodule

@@ files.f @@
+incdir+design
design/ssr_pkg.sv
design/stereo_schroeder_reverb_q15.sv
design/ssr_checker.sv
bench/stereo_schroeder_reverb_q15_test.sv
